[sv/dq_pkg.sv]
// dq_pkg: shared constants, codes and types for the double-ended queue
// depends on nothing; used by dq_if.sv, dq_store.sv and double_ended_queue.sv
package dq_pkg;

   localparam int DEPTH   = 32;
   localparam int SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int VALUE_W = 32;
   localparam int MODE_W  = 3;
   localparam int STAT_W  = 3;

   typedef logic [SLOT_W-1:0]         slot_type;
   typedef logic [CNT_W-1:0]          count_type;
   typedef logic signed [VALUE_W-1:0] value_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_REAR  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_REAR   = 3'd3,
      MODE_DUMP       = 3'd4
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_DONE       = 3'd0,
      STAT_UNDERFLOW  = 3'd1,
      STAT_OVERFLOW   = 3'd2,
      STAT_DUMPED     = 3'd3,
      STAT_EMPTY_DUMP = 3'd4
   } status_type;

   // one write and one read access to the element store per cycle
   typedef struct packed {
      logic      wr_en;
      slot_type  wr_addr;
      value_type wr_data;
      logic      rd_en;
      slot_type  rd_addr;
   } mem_req_type;

endpackage

[sv/dq_if.sv]
// dq_req_if and dq_rsp_if: valid/ready channels of the double-ended queue
// depends on dq_pkg
interface dq_req_if;
   import dq_pkg::*;

   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   value_type           value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

interface dq_rsp_if;
   import dq_pkg::*;

   logic         valid;
   logic         ready;
   status_type   status;
   value_type    value_res;
   logic         last;

   modport source (output valid, output status, output value_res, output last, input ready);
   modport sink   (input valid, input status, input value_res, input last, output ready);
endinterface

[sv/dq_store.sv]
// dq_store: element ring storage, one write and one registered read per cycle
// depends on dq_pkg
module dq_store (
   input  logic                 clock,
   input  dq_pkg::mem_req_type  mem_req,
   output dq_pkg::value_type    rd_data
);
   import dq_pkg::*;

   value_type mem [DEPTH];
   value_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // read data holds until the next read, so a stalled result keeps it
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/double_ended_queue.sv]
// double_ended_queue: bounded deque of signed 32-bit values on a ring buffer
// depends on dq_pkg, dq_if (dq_req_if, dq_rsp_if) and dq_store
//
// Each request transfer carries a mode and a value: push front, push rear,
// pop front, pop rear or dump. A push answers with one done response (or
// overflow when all DEPTH slots are in use); the next request can transfer
// in the following cycle while the response side keeps up. A pop answers
// with the removed value (or underflow when empty); the value goes through
// the single registered read port of the element store and then the output
// register, and no new request is taken until its response is loaded.
// A dump streams every stored element from front to rear, one per cycle
// while the response side keeps up, with last set on the rear element, and
// an empty store gives one empty-dump response. Unused mode codes are taken
// and produce no response. The store needs no clearing after reset: only
// slots that hold live elements are read. The response sits in an output
// register; a new request is taken while the previous response is being
// transferred in the same cycle.
module double_ended_queue (
   input  logic      clock,
   input  logic      reset,
   dq_req_if.sink    req,
   dq_rsp_if.source  rsp
);
   import dq_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   localparam slot_type  LAST_SLOT = SLOT_W'(DEPTH - 1);
   localparam count_type FULL_CNT  = CNT_W'(DEPTH);

   function automatic slot_type slot_next(slot_type s);
      return (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
   endfunction

   function automatic slot_type slot_prev(slot_type s);
      return (s == '0) ? LAST_SLOT : s - SLOT_W'(1);
   endfunction

   // control state
   state_type  state_ff,     state_in;
   slot_type   front_ff,     front_in;
   slot_type   rear_ff,      rear_in;
   count_type  count_ff,     count_in;
   logic       rsp_valid_ff, rsp_valid_in;
   // dump walk: next slot to read and elements still to send
   slot_type   dump_slot_ff, dump_slot_in;
   count_type  remain_ff,    remain_in;
   logic       is_dump_ff,   is_dump_in;
   // response payload
   status_type rsp_status_ff;
   value_type  rsp_value_ff;
   logic       rsp_last_ff;

   logic        out_free;
   logic        accept;
   logic        load;
   status_type  ld_status;
   value_type   ld_value;
   logic        ld_last;
   mem_req_type mem_req;
   value_type   rd_data;

   dq_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // output register is free when empty or being transferred this cycle
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req.valid && req.ready;

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      rear_in      = rear_ff;
      count_in     = count_ff;
      dump_slot_in = dump_slot_ff;
      remain_in    = remain_ff;
      is_dump_in   = is_dump_ff;
      load         = 1'b0;
      ld_status    = STAT_DONE;
      ld_value     = '0;
      ld_last      = 1'b1;
      mem_req         = '0;
      mem_req.wr_data = req.value;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req.mode)
                  MODE_PUSH_FRONT: begin
                     load = 1'b1;
                     if (count_ff == FULL_CNT) begin
                        ld_status = STAT_OVERFLOW;
                     end else begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = slot_prev(front_ff);
                        front_in        = slot_prev(front_ff);
                        count_in        = count_ff + CNT_W'(1);
                     end
                  end
                  MODE_PUSH_REAR: begin
                     load = 1'b1;
                     if (count_ff == FULL_CNT) begin
                        ld_status = STAT_OVERFLOW;
                     end else begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = rear_ff;
                        rear_in         = slot_next(rear_ff);
                        count_in        = count_ff + CNT_W'(1);
                     end
                  end
                  MODE_POP_FRONT: begin
                     if (count_ff == '0) begin
                        load      = 1'b1;
                        ld_status = STAT_UNDERFLOW;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = front_ff;
                        front_in        = slot_next(front_ff);
                        count_in        = count_ff - CNT_W'(1);
                        is_dump_in      = 1'b0;
                        state_in        = ST_READ;
                     end
                  end
                  MODE_POP_REAR: begin
                     if (count_ff == '0) begin
                        load      = 1'b1;
                        ld_status = STAT_UNDERFLOW;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = slot_prev(rear_ff);
                        rear_in         = slot_prev(rear_ff);
                        count_in        = count_ff - CNT_W'(1);
                        is_dump_in      = 1'b0;
                        state_in        = ST_READ;
                     end
                  end
                  MODE_DUMP: begin
                     if (count_ff == '0) begin
                        load      = 1'b1;
                        ld_status = STAT_EMPTY_DUMP;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = front_ff;
                        dump_slot_in    = slot_next(front_ff);
                        remain_in       = count_ff;
                        is_dump_in      = 1'b1;
                        state_in        = ST_READ;
                     end
                  end
                  default: ;  // unused codes produce nothing
               endcase
            end
         end
         ST_READ: begin
            // read data is held by the store until the response has room
            if (out_free) begin
               load     = 1'b1;
               ld_value = rd_data;
               if (is_dump_ff) begin
                  ld_status = STAT_DUMPED;
                  ld_last   = (remain_ff == CNT_W'(1));
                  if (remain_ff == CNT_W'(1)) begin
                     state_in = ST_IDLE;
                  end else begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = dump_slot_ff;
                     dump_slot_in    = slot_next(dump_slot_ff);
                     remain_in       = remain_ff - CNT_W'(1);
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         rear_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         dump_slot_ff <= '0;
         remain_ff    <= '0;
         is_dump_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         dump_slot_ff <= dump_slot_in;
         remain_ff    <= remain_in;
         is_dump_ff   <= is_dump_in;
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_status_ff <= ld_status;
         rsp_value_ff  <= ld_value;
         rsp_last_ff   <= ld_last;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = rsp_status_ff;
   assign rsp.value_res = rsp_value_ff;
   assign rsp.last      = rsp_last_ff;

`ifndef SYNTHESIS
   // fill level never goes past the ring size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count exceeds depth");

   // rear slot always sits count entries past the front, modulo depth
   a_ring_consistent: assert property (@(posedge clock) disable iff (reset)
      (((32'(front_ff) + 32'(count_ff)) >= 32'(DEPTH)) ?
         (32'(front_ff) + 32'(count_ff) - 32'(DEPTH)) :
         (32'(front_ff) + 32'(count_ff))) == 32'(rear_ff))
      else $error("front, rear and count disagree");

   // no store write while a pop or dump read is in flight
   a_no_write_in_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !mem_req.wr_en)
      else $error("store written during read phase");

   // a push into a store with room grows the count by one
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && (req.mode == MODE_PUSH_FRONT || req.mode == MODE_PUSH_REAR)
         && count_ff != FULL_CNT) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("push did not grow the count");
`endif

endmodule

[bench/tb_double_ended_queue.sv]
`timescale 1ns / 100ps
// tb_double_ended_queue: self-checking bench for the double-ended queue
// depends on dq_pkg, dq_if (dq_req_if, dq_rsp_if) and double_ended_queue
module tb_double_ended_queue;
   import dq_pkg::*;

   // mode codes the block takes and drops without a response
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   localparam int LIMIT_CYCLES   = 400000;
   localparam int OPS_PER_PHASE  = 38;
   localparam int REPORT_LIMIT   = 10;
   localparam int SETTLE_CYCLES  = 2 * DEPTH + 8;

   // one operation as it travels on the request channel
   typedef struct {
      logic [MODE_W-1:0] mode;
      value_type         value;
   } deque_op_type;

   // one response as the block should send it
   typedef struct {
      status_type status;
      value_type  value_res;
      logic       last;
   } deque_rsp_type;

   logic clock;
   logic reset;

   dq_req_if req_ch ();
   dq_rsp_if rsp_ch ();

   double_ended_queue uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // operations waiting to be driven, in order
   deque_op_type  op_backlog[$];
   // responses owed by the block, oldest first
   deque_rsp_type rsp_due[$];
   // contents of the queue as the bench sees them, front at index 0
   value_type  shadow_deque[$];

   // occupancy as the stimulus planner sees it, ahead of the block
   int plan_level;
   // operations queued that the block acts on (spare modes not counted)
   int planned_ops;

   int send_idle_pct;
   int recv_stall_pct;
   int fault_count;
   int cycle_count;

   deque_op_type  drive_op;
   deque_rsp_type want_rsp;

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: the slowest correct run ends far below this
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL double_ended_queue");
      $finish;
   end

   // expected responses for one accepted operation
   function automatic void apply_deque_op(logic [MODE_W-1:0] mode, value_type val);
      deque_rsp_type r;
      value_type     popped;
      case (mode)
         MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
            if (shadow_deque.size() >= DEPTH) begin
               // full: nothing stored
               r = '{status: STAT_OVERFLOW, value_res: '0, last: 1'b1};
            end else begin
               if (mode == MODE_PUSH_FRONT)
                  shadow_deque.push_front(val);
               else
                  shadow_deque.push_back(val);
               r = '{status: STAT_DONE, value_res: '0, last: 1'b1};
            end
            rsp_due.push_back(r);
         end
         MODE_POP_FRONT, MODE_POP_REAR: begin
            if (shadow_deque.size() == 0) begin
               // empty: store left alone
               r = '{status: STAT_UNDERFLOW, value_res: '0, last: 1'b1};
            end else begin
               if (mode == MODE_POP_FRONT)
                  popped = shadow_deque.pop_front();
               else
                  popped = shadow_deque.pop_back();
               r = '{status: STAT_DONE, value_res: popped, last: 1'b1};
            end
            rsp_due.push_back(r);
         end
         MODE_DUMP: begin
            if (shadow_deque.size() == 0) begin
               r = '{status: STAT_EMPTY_DUMP, value_res: '0, last: 1'b1};
               rsp_due.push_back(r);
            end else begin
               // front to rear, last flag only on the rear element
               foreach (shadow_deque[i]) begin
                  r = '{status: STAT_DUMPED, value_res: shadow_deque[i],
                        last: (i == shadow_deque.size() - 1)};
                  rsp_due.push_back(r);
               end
            end
         end
         default: ;  // spare codes: no response, no state change
      endcase
   endfunction

   // queue an operation and keep the planner's idea of the fill level current
   task automatic queue_op(logic [MODE_W-1:0] mode, value_type val);
      deque_op_type op;
      op.mode  = mode;
      op.value = val;
      op_backlog.push_back(op);
      case (mode)
         MODE_PUSH_FRONT, MODE_PUSH_REAR: if (plan_level < DEPTH) plan_level++;
         MODE_POP_FRONT, MODE_POP_REAR:   if (plan_level > 0) plan_level--;
         default: ;
      endcase
      if (mode <= MODE_DUMP)
         planned_ops++;
   endtask

   // push data: random words half the time, corner values the other half
   function automatic value_type pick_value();
      case ($urandom_range(7))
         0:       return {1'b0, {(VALUE_W-1){1'b1}}};
         1:       return {1'b1, {(VALUE_W-1){1'b0}}};
         2:       return '0;
         3:       return '1;
         default: return value_type'($urandom);
      endcase
   endfunction

   function automatic logic [MODE_W-1:0] pick_push();
      return $urandom_range(1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
   endfunction

   function automatic logic [MODE_W-1:0] pick_pop();
      return $urandom_range(1) ? MODE_POP_REAR : MODE_POP_FRONT;
   endfunction

   // push until full, then bang on the full store and sometimes dump it
   task automatic fill_burst();
      while (plan_level < DEPTH)
         queue_op(pick_push(), pick_value());
      repeat ($urandom_range(1, 3)) queue_op(pick_push(), pick_value());
      if ($urandom_range(1))
         queue_op(MODE_DUMP, pick_value());
   endtask

   // pop until empty, then poke the empty store and sometimes dump it
   task automatic drain_burst();
      while (plan_level > 0)
         queue_op(pick_pop(), pick_value());
      repeat ($urandom_range(1, 2)) queue_op(pick_pop(), pick_value());
      if ($urandom_range(1))
         queue_op(MODE_DUMP, pick_value());
   endtask

   // random mix of pushes, pops, dumps and spare codes, biased toward pushes so the level wanders
   task automatic mixed_burst();
      int pick;
      repeat ($urandom_range(6, 14)) begin
         pick = $urandom_range(99);
         if (pick < 27)
            queue_op(MODE_PUSH_FRONT, pick_value());
         else if (pick < 54)
            queue_op(MODE_PUSH_REAR, pick_value());
         else if (pick < 72)
            queue_op(MODE_POP_FRONT, pick_value());
         else if (pick < 90)
            queue_op(MODE_POP_REAR, pick_value());
         else if (pick < 96)
            queue_op(MODE_DUMP, pick_value());
         else
            queue_op(MODE_W'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO)),
                     pick_value());
      end
   endtask

   // wait until every operation is out and every response is back
   task automatic wait_drained();
      while (op_backlog.size() != 0 || req_ch.valid || rsp_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic note_fault(string msg);
      if (fault_count < REPORT_LIMIT)
         $display("%s", msg);
      fault_count++;
   endtask

   // request driver: a new operation goes out once the previous one has
   // transferred or the channel is idle; the prediction is made at the
   // transfer edge from the values that were on the wires
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            apply_deque_op(req_ch.mode, req_ch.value);
         if (!req_ch.valid || req_ch.ready) begin
            if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               drive_op = op_backlog.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.mode  <= drive_op.mode;
               req_ch.value <= drive_op.value;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and receiver backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (rsp_due.size() == 0) begin
               note_fault($sformatf("unexpected response: status %0d value %0d last %0b",
                                    rsp_ch.status, rsp_ch.value_res, rsp_ch.last));
            end else begin
               want_rsp = rsp_due.pop_front();
               if (rsp_ch.status !== want_rsp.status ||
                   rsp_ch.value_res !== want_rsp.value_res ||
                   rsp_ch.last !== want_rsp.last)
                  note_fault($sformatf({"response mismatch: status exp %0d got %0d, ",
                                        "value exp %0d got %0d, last exp %0b got %0b"},
                                       want_rsp.status, rsp_ch.status,
                                       want_rsp.value_res, rsp_ch.value_res,
                                       want_rsp.last, rsp_ch.last));
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // idle and stall rates per phase: clean, slow sender, slow receiver, both
   int phase_idle[4]  = '{0, 73, 0, 25};
   int phase_stall[4] = '{0, 0, 73, 25};

   initial begin
      int phase_start;
      int kind;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.mode    = MODE_PUSH_FRONT;
      req_ch.value   = '0;
      rsp_ch.ready   = 1'b0;
      plan_level     = 0;
      planned_ops    = 0;
      fault_count    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed opening: empty-store cases first, then corner data,
      // ring wrap on a front push from slot zero, and the spare codes
      queue_op(MODE_DUMP, '0);
      queue_op(MODE_POP_FRONT, '0);
      queue_op(MODE_POP_REAR, '1);
      queue_op(MODE_PUSH_FRONT, {1'b0, {(VALUE_W-1){1'b1}}});
      queue_op(MODE_PUSH_REAR, {1'b1, {(VALUE_W-1){1'b0}}});
      queue_op(MODE_PUSH_FRONT, '0);
      queue_op(MODE_PUSH_REAR, '1);
      queue_op(MODE_DUMP, '0);
      for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
         queue_op(MODE_W'(m), value_type'($urandom));
      queue_op(MODE_POP_FRONT, '0);
      queue_op(MODE_POP_REAR, '0);
      queue_op(MODE_POP_FRONT, '0);
      queue_op(MODE_POP_FRONT, '0);
      queue_op(MODE_POP_REAR, '0);
      queue_op(MODE_PUSH_REAR, 32'h5555_5555);
      queue_op(MODE_PUSH_FRONT, 32'hAAAA_AAAA);
      queue_op(MODE_DUMP, '0);
      queue_op(MODE_POP_REAR, '0);
      queue_op(MODE_POP_REAR, '0);
      queue_op(MODE_DUMP, '0);

      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = phase_idle[p];
         recv_stall_pct = phase_stall[p];
         phase_start    = planned_ops;
         // odd phases open with a fill burst, which may end in a dump of the full store
         if (p % 2 == 1)
            fill_burst();
         while (planned_ops - phase_start < OPS_PER_PHASE) begin
            kind = $urandom_range(9);
            if (kind < 2)
               fill_burst();
            else if (kind < 4)
               drain_burst();
            else
               mixed_burst();
         end
         wait_drained();
      end

      // let any trailing activity show up as an unexpected response
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fault_count == 0 && rsp_due.size() == 0)
         $display("PASS double_ended_queue");
      else
         $display("FAIL double_ended_queue");
      $finish;
   end

endmodule
